>>> hdl/biquad_df2_filter_assert.svh
// Assertion macros used by the biquad filter checker.
`ifndef BIQUAD_DF2_FILTER_ASSERT_SVH
`define BIQUAD_DF2_FILTER_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define BQD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define BQD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bqd_pkg.sv
// Package for the biquad filter: constants, register indexes and the microprogram.
package bqd_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int COEF_W             = 32;
  localparam int STATE_W            = 32;
  localparam int CFG_IDX_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MA_A1,
    MA_A2,
    MA_B0,
    MA_B1,
    MA_B2
  } mul_a_sel_t;

  typedef enum logic [1:0] {
    MB_W1,
    MB_W2,
    MB_D
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    ACC_LOAD_X,
    ACC_SUB,
    ACC_SUB_SAT_D,
    ACC_LOAD_P,
    ACC_ADD,
    ACC_ADD_OUT
  } acc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT_JUMP
  } seq_cond_t;

  localparam int UCODE_DEPTH = 6;
  localparam int STEP_W      = $clog2(UCODE_DEPTH);

  typedef struct packed {
    mul_a_sel_t        mul_a;
    mul_b_sel_t        mul_b;
    acc_op_t           acc_op;
    seq_cond_t         cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // One word per step. The multiplier result lands a step later, so each word
  // after the first uses the product that the previous word started.
  localparam ctrl_word_t UCODE [0:UCODE_DEPTH-1] = '{
    '{MA_A1, MB_W1, ACC_LOAD_X,    SEQ_WAIT_IN,       STEP_W'(0)},
    '{MA_A2, MB_W2, ACC_SUB,       SEQ_NEXT,          STEP_W'(0)},
    '{MA_B1, MB_W1, ACC_SUB_SAT_D, SEQ_NEXT,          STEP_W'(0)},
    '{MA_B0, MB_D,  ACC_LOAD_P,    SEQ_NEXT,          STEP_W'(0)},
    '{MA_B2, MB_W2, ACC_ADD,       SEQ_NEXT,          STEP_W'(0)},
    '{MA_A1, MB_W1, ACC_ADD_OUT,   SEQ_WAIT_OUT_JUMP, STEP_W'(0)}
  };

endpackage

>>> hdl/biquad_df2_filter.sv
// Biquad direct form II filter built on one shared multiply-accumulate.
// A six-word microprogram steps one 32x32 multiplier and one accumulator
// through the five coefficient products of each accepted sample until its
// result sits in the output register, and the next sample is taken in the
// step that follows. A result that is not yet taken holds the sequencer only
// in its final step; a new sample is not taken until the previous one is
// through. The delay words are saturated to 32 bits, the output to the sample
// width; products are truncated toward minus infinity before they are summed.
module biquad_df2_filter
  import bqd_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data
);

  localparam int PROD_W = COEF_W + STATE_W;
  localparam int PSH_W  = PROD_W - COEF_FRAC_BITS;
  localparam int ACC_W  = PSH_W + 2;
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  logic signed [COEF_W-1:0]      b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [STATE_W-1:0]     w1_r, w2_r, d_r;
  logic signed [STATE_W-1:0]     d_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, y_sat;

  ctrl_word_t                    ctrl;
  logic                          go;
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [STATE_W-1:0]     mul_b;
  logic signed [PSH_W-1:0]       psh_raw;
  logic signed [ACC_W-1:0]       psh, sub_sum, add_sum;
  logic [ACC_W-STATE_W:0]        d_top;
  logic [ACC_W-SAMPLE_BITS:0]    y_top;

  assign ctrl = UCODE[step_r];

  // The current step may execute only when its wait condition is met.
  always_comb begin
    unique case (ctrl.cond)
      SEQ_WAIT_IN:       go = in_valid;
      SEQ_WAIT_OUT_JUMP: go = !out_valid_r || out_ready;
      default:           go = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (go) begin
      if (ctrl.cond == SEQ_WAIT_OUT_JUMP) begin
        step_nxt = ctrl.target;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  assign in_ready  = (ctrl.cond == SEQ_WAIT_IN);
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (ctrl.mul_a)
      MA_A1:   mul_a = a1_r;
      MA_A2:   mul_a = a2_r;
      MA_B0:   mul_a = b0_r;
      MA_B1:   mul_a = b1_r;
      MA_B2:   mul_a = b2_r;
      default: mul_a = a1_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.mul_b)
      MB_W1:   mul_b = w1_r;
      MB_W2:   mul_b = w2_r;
      MB_D:    mul_b = d_r;
      default: mul_b = w1_r;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Arithmetic shift of the registered product rounds toward minus infinity.
  assign psh_raw = prod_r[PROD_W-1:COEF_FRAC_BITS];
  assign psh     = ACC_W'(psh_raw);
  assign sub_sum = acc_r - psh;
  assign add_sum = acc_r + psh;

  assign d_top = sub_sum[ACC_W-1:STATE_W-1];
  assign y_top = add_sum[ACC_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&d_top) || !(|d_top)) begin
      d_nxt = sub_sum[STATE_W-1:0];
    end else if (sub_sum[ACC_W-1]) begin
      d_nxt = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      d_nxt = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_sat = add_sum[SAMPLE_BITS-1:0];
    end else if (add_sum[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    unique case (ctrl.acc_op)
      ACC_LOAD_X: acc_nxt = ACC_W'(in_sample_in);
      ACC_SUB:    acc_nxt = sub_sum;
      ACC_LOAD_P: acc_nxt = psh;
      ACC_ADD:    acc_nxt = add_sum;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && ctrl.acc_op == ACC_ADD_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
      w1_r        <= '0;
      w2_r        <= '0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (go && ctrl.acc_op == ACC_ADD_OUT) begin
        w2_r <= w1_r;
        w1_r <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      if (ctrl.acc_op == ACC_SUB_SAT_D) begin
        d_r <= d_nxt;
      end
      if (ctrl.acc_op == ACC_ADD_OUT) begin
        out_sample_r <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= COEF_ONE;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_B0:  b0_r <= cfg_data;
        REG_B1:  b1_r <= cfg_data;
        REG_B2:  b2_r <= cfg_data;
        REG_A1:  a1_r <= cfg_data;
        REG_A2:  a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

>>> hdl/bqd_checker.sv
// Port-level checker for the biquad filter, bound to the top level.
`include "biquad_df2_filter_assert.svh"

module bqd_checker
  import bqd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out
);

  // A stalled result keeps its value until it is taken.
  `BQD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_out), "stalled result changed")

  // Only one sample is in work at a time.
  `BQD_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "request taken while a sample is in work")

  // An accepted request is followed by a valid result in the output register.
  `BQD_ASSERT_IMP(a_latency, in_valid && in_ready, ##6 out_valid, "result missing after request")

  // A new result appears only as the sequencer finishes a sample.
  `BQD_ASSERT_IMP(a_out_src, $rose(out_valid), !$past(in_ready), "result appeared while idle")

endmodule

bind biquad_df2_filter bqd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bqd_checker (.*);
